/* sv/gaq_pkg.sv */
// gesture action qualifier package: item and config types, codes, reset values
// and the cooldown compare helper
// depends on nothing; used by gaq_cfg_regs and gesture_action_qualifier_unit
package gaq_pkg;

  // gesture class codes carried in best_class
  localparam logic [3:0] CLS_NONE    = 4'd0;
  localparam logic [3:0] CLS_OK      = 4'd1;
  localparam logic [3:0] CLS_ONE     = 4'd2;
  localparam logic [3:0] CLS_TWO     = 4'd3;
  localparam logic [3:0] CLS_THREE   = 4'd4;
  localparam logic [3:0] CLS_FOUR    = 4'd5;
  localparam logic [3:0] CLS_FIVE    = 4'd6;
  localparam logic [3:0] CLS_LIKE    = 4'd7;
  localparam logic [3:0] CLS_DISLIKE = 4'd8;

  // repeat counter saturation value
  localparam logic [7:0] COUNT_MAX = 8'd255;

  // action codes
  typedef enum logic [3:0] {
    ACT_NONE       = 4'd0,
    ACT_PHOTO      = 4'd1,
    ACT_VIDEO      = 4'd2,
    ACT_PLAY_PAUSE = 4'd3,
    ACT_NEXT       = 4'd4,
    ACT_PREV       = 4'd5,
    ACT_VOL_UP     = 4'd6,
    ACT_VOL_DOWN   = 4'd7,
    ACT_EMERGENCY  = 4'd8
  } action_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_SCORE_THRESHOLD = 3'd0,
    CFG_STABLE_FRAMES   = 3'd1,
    CFG_PHOTO_COOLDOWN  = 3'd2,
    CFG_VIDEO_COOLDOWN  = 3'd3,
    CFG_KEY_COOLDOWN    = 3'd4,
    CFG_ALARM_COOLDOWN  = 3'd5,
    CFG_ALARM_MIN_HANDS = 3'd6
  } cfg_idx_e;

  // configuration reset values
  localparam logic [15:0] RST_SCORE_THRESHOLD = 16'd26214;
  localparam logic [7:0]  RST_STABLE_FRAMES   = 8'd2;
  localparam logic [31:0] RST_PHOTO_COOLDOWN  = 32'd2000000;
  localparam logic [31:0] RST_VIDEO_COOLDOWN  = 32'd12000000;
  localparam logic [31:0] RST_KEY_COOLDOWN    = 32'd500000;
  localparam logic [31:0] RST_ALARM_COOLDOWN  = 32'd5000000;
  localparam logic [3:0]  RST_ALARM_MIN_HANDS = 4'd2;

  // configuration register set
  typedef struct packed {
    logic [15:0] score_threshold;
    logic [7:0]  stable_frames;
    logic [31:0] photo_cooldown;
    logic [31:0] video_cooldown;
    logic [31:0] media_key_cooldown;
    logic [31:0] alarm_cooldown;
    logic [3:0]  alarm_min_hands;
  } cfg_t;

  // one summarized frame result
  typedef struct packed {
    logic        link_busy;
    logic        hand_detected;
    logic        best_valid;
    logic [3:0]  best_class;
    logic [15:0] best_score;
    logic [3:0]  palm_votes;
    logic [62:0] now_time;
  } in_item_t;

  // cooldown test: time must not run backwards and the gap must be covered
  function automatic logic cooled(logic [62:0] now, logic [62:0] last, logic [31:0] gap);
    logic [62:0] diff;
    diff = now - last;
    return (now >= last) && (diff >= {31'd0, gap});
  endfunction

endpackage

/* sv/gaq_cfg_regs.sv */
// configuration register file of the gesture action qualifier
// depends on gaq_pkg for the register set type, indexes and reset values
module gaq_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i,
  output gaq_pkg::cfg_t     cfg_o
);

  gaq_pkg::cfg_t cfg_q;

  // register writes, unused index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.score_threshold    <= gaq_pkg::RST_SCORE_THRESHOLD;
      cfg_q.stable_frames      <= gaq_pkg::RST_STABLE_FRAMES;
      cfg_q.photo_cooldown     <= gaq_pkg::RST_PHOTO_COOLDOWN;
      cfg_q.video_cooldown     <= gaq_pkg::RST_VIDEO_COOLDOWN;
      cfg_q.media_key_cooldown <= gaq_pkg::RST_KEY_COOLDOWN;
      cfg_q.alarm_cooldown     <= gaq_pkg::RST_ALARM_COOLDOWN;
      cfg_q.alarm_min_hands    <= gaq_pkg::RST_ALARM_MIN_HANDS;
    end else if (cfg_we_i) begin
      unique case (gaq_pkg::cfg_idx_e'(cfg_idx_i))
        gaq_pkg::CFG_SCORE_THRESHOLD: cfg_q.score_threshold    <= cfg_wdata_i[15:0];
        gaq_pkg::CFG_STABLE_FRAMES:   cfg_q.stable_frames      <= cfg_wdata_i[7:0];
        gaq_pkg::CFG_PHOTO_COOLDOWN:  cfg_q.photo_cooldown     <= cfg_wdata_i;
        gaq_pkg::CFG_VIDEO_COOLDOWN:  cfg_q.video_cooldown     <= cfg_wdata_i;
        gaq_pkg::CFG_KEY_COOLDOWN:    cfg_q.media_key_cooldown <= cfg_wdata_i;
        gaq_pkg::CFG_ALARM_COOLDOWN:  cfg_q.alarm_cooldown     <= cfg_wdata_i;
        gaq_pkg::CFG_ALARM_MIN_HANDS: cfg_q.alarm_min_hands    <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/gesture_action_qualifier_unit.sv */
// an input transfer passes the input register, then the decision and result register,
// before the matching output transfer
// throughput: one frame result per cycle while the output is not stalled; the label,
// count, presence and cooldown state is updated once per item in the decision logic
// reset: tracking state and cooldown times clear to zero, registers to defaults
// top level of the gesture action qualifier; depends on gaq_pkg and gaq_cfg_regs
module gesture_action_qualifier_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // link_busy[0], hand_detected[1], best_valid[2], best_class[6:3],
  // best_score[22:7], palm_votes[26:23], now_time[89:27], zero fill [95:90]
  input  logic [95:0] s_tdata_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // action[3:0], hand_appeared[4], zero fill [7:5]
  output logic [7:0]  m_tdata_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  gaq_pkg::cfg_t     cfg;
  gaq_pkg::in_item_t in_d, in_q;
  logic              in_valid_q, out_valid_q;
  logic              advance, proc;

  // tracking state
  logic              label_valid_q, label_valid_d;
  logic [3:0]        tracked_q, tracked_d;
  logic [7:0]        count_q, count_d;
  logic              hand_seen_q, hand_seen_d;
  logic [62:0]       photo_t_q, photo_t_d;
  logic [62:0]       video_t_q, video_t_d;
  logic [62:0]       key_t_q, key_t_d;
  logic [62:0]       alarm_t_q, alarm_t_d;

  // result
  gaq_pkg::action_e  action_d, action_q;
  logic              appeared_d, appeared_q;
  logic [7:0]        count_new;

  gaq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // unpack input transfer
  assign in_d.link_busy     = s_tdata_i[0];
  assign in_d.hand_detected = s_tdata_i[1];
  assign in_d.best_valid    = s_tdata_i[2];
  assign in_d.best_class    = s_tdata_i[6:3];
  assign in_d.best_score    = s_tdata_i[22:7];
  assign in_d.palm_votes    = s_tdata_i[26:23];
  assign in_d.now_time      = s_tdata_i[89:27];

  // handshake: the result register frees when taken, the input register when moved on
  assign advance    = !out_valid_q || m_tready_i;
  assign proc       = in_valid_q && advance;
  assign s_tready_o = !in_valid_q || advance;

  // decision logic for the item in the input register
  always_comb begin
    label_valid_d = label_valid_q;
    tracked_d     = tracked_q;
    count_d       = count_q;
    hand_seen_d   = hand_seen_q;
    photo_t_d     = photo_t_q;
    video_t_d     = video_t_q;
    key_t_d       = key_t_q;
    alarm_t_d     = alarm_t_q;
    action_d      = gaq_pkg::ACT_NONE;
    appeared_d    = 1'b0;
    count_new     = 8'd1;
    if (label_valid_q && (tracked_q == in_q.best_class)) begin
      count_new = (count_q < gaq_pkg::COUNT_MAX) ? count_q + 8'd1 : count_q;
    end
    priority if (in_q.link_busy) begin
      label_valid_d = 1'b0;
      count_d       = 8'd0;
      hand_seen_d   = 1'b0;
    end else if (!in_q.hand_detected) begin
      hand_seen_d = 1'b0;
    end else begin
      appeared_d  = !hand_seen_q;
      hand_seen_d = 1'b1;
      if (!in_q.best_valid || (in_q.best_score < cfg.score_threshold) ||
          (in_q.best_class == gaq_pkg::CLS_NONE)) begin
        label_valid_d = 1'b0;
        count_d       = 8'd0;
      end else begin
        label_valid_d = 1'b1;
        tracked_d     = in_q.best_class;
        count_d       = count_new;
        if (count_new >= cfg.stable_frames) begin
          // priority: emergency, photo, video, then shared media keys
          priority if ((in_q.best_class == gaq_pkg::CLS_FIVE) &&
                       (in_q.palm_votes >= cfg.alarm_min_hands)) begin
            if (gaq_pkg::cooled(in_q.now_time, alarm_t_q, cfg.alarm_cooldown)) begin
              alarm_t_d = in_q.now_time;
              action_d  = gaq_pkg::ACT_EMERGENCY;
            end
          end else if (in_q.best_class == gaq_pkg::CLS_OK) begin
            if (gaq_pkg::cooled(in_q.now_time, photo_t_q, cfg.photo_cooldown)) begin
              photo_t_d = in_q.now_time;
              action_d  = gaq_pkg::ACT_PHOTO;
            end
          end else if (in_q.best_class == gaq_pkg::CLS_ONE) begin
            if (gaq_pkg::cooled(in_q.now_time, video_t_q, cfg.video_cooldown)) begin
              video_t_d = in_q.now_time;
              action_d  = gaq_pkg::ACT_VIDEO;
            end
          end else if (gaq_pkg::cooled(in_q.now_time, key_t_q, cfg.media_key_cooldown)) begin
            priority if (in_q.best_class == gaq_pkg::CLS_TWO) begin
              action_d = gaq_pkg::ACT_PLAY_PAUSE;
            end else if (in_q.best_class == gaq_pkg::CLS_THREE) begin
              action_d = gaq_pkg::ACT_NEXT;
            end else if (in_q.best_class == gaq_pkg::CLS_FOUR) begin
              action_d = gaq_pkg::ACT_PREV;
            end else if (in_q.best_class == gaq_pkg::CLS_LIKE) begin
              action_d = gaq_pkg::ACT_VOL_UP;
            end else if (in_q.best_class == gaq_pkg::CLS_DISLIKE) begin
              action_d = gaq_pkg::ACT_VOL_DOWN;
            end else begin
              action_d = gaq_pkg::ACT_NONE;
            end
            if (action_d != gaq_pkg::ACT_NONE) begin
              key_t_d = in_q.now_time;
            end
          end
          if (action_d != gaq_pkg::ACT_NONE) begin
            count_d = 8'd0;
          end
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      in_valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      in_q <= in_d;
    end
  end

  // tracking state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_valid_q <= 1'b0;
      tracked_q     <= 4'd0;
      count_q       <= 8'd0;
      hand_seen_q   <= 1'b0;
      photo_t_q     <= 63'd0;
      video_t_q     <= 63'd0;
      key_t_q       <= 63'd0;
      alarm_t_q     <= 63'd0;
    end else if (proc) begin
      label_valid_q <= label_valid_d;
      tracked_q     <= tracked_d;
      count_q       <= count_d;
      hand_seen_q   <= hand_seen_d;
      photo_t_q     <= photo_t_d;
      video_t_q     <= video_t_d;
      key_t_q       <= key_t_d;
      alarm_t_q     <= alarm_t_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      action_q   <= action_d;
      appeared_q <= appeared_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {3'b000, appeared_q, action_q};

`ifndef SYNTHESIS
  // a busy frame clears the label, the repeat count and hand presence
  a_busy_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_q.link_busy |=> !label_valid_q && !hand_seen_q && (count_q == 8'd0))
    else $error("busy frame left tracking state set");

  // a fired action restarts the count
  a_fire_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && (action_d != gaq_pkg::ACT_NONE) |=> (count_q == 8'd0) && label_valid_q)
    else $error("fired action did not clear the repeat count");

  // without a valid label the count is zero
  a_count_needs_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !label_valid_q |-> (count_q == 8'd0))
    else $error("repeat count nonzero without a valid label");

  // an appeared pulse marks the hand as present afterwards
  a_appear_sets_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && appeared_d |=> hand_seen_q && $past(!hand_seen_q))
    else $error("hand appeared pulse without presence change");
`endif

endmodule

/* tb/sv/gesture_action_qualifier_unit_tb.sv */
// self-checking testbench for gesture_action_qualifier_unit: frame results go in on the
// input stream, predicted actions and hand-appeared pulses are checked on the output stream
// depends on gaq_pkg and the gesture_action_qualifier_unit rtl
module gesture_action_qualifier_unit_tb;

  // classes above dislike track like gestures but map to no action
  localparam logic [3:0] CLS_OTHER_MAX = 4'd15;
  // register index with no register behind it
  localparam logic [2:0] CFG_IDX_SPARE = 3'd7;

  // expected output of one frame
  typedef struct packed {
    gaq_pkg::action_e act;
    logic             appeared;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  // link_busy, hand_detected, best_valid, best_class, best_score, palm_votes,
  // now_time, zero fill
  logic [95:0] s_tdata_i = '0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  // action, hand_appeared, zero fill
  logic [7:0]  m_tdata_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  gesture_action_qualifier_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // frames waiting to go in, verdicts waiting to come out
  gaq_pkg::in_item_t frame_q[$];
  verdict_t          verdict_q[$];
  verdict_t          due_verdict;
  int unsigned       error_count = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  logic [62:0]       clock_us = '0;

  // predictor copy of the configuration
  logic [15:0] thr;
  logic [7:0]  need_frames;
  logic [31:0] cd_photo;
  logic [31:0] cd_video;
  logic [31:0] cd_key;
  logic [31:0] cd_alarm;
  logic [3:0]  min_hands;

  // predictor copy of the tracking state
  logic        trk_valid;
  logic [3:0]  trk_class;
  logic [7:0]  trk_count;
  logic        trk_hand;
  logic [62:0] t_photo;
  logic [62:0] t_video;
  logic [62:0] t_key;
  logic [62:0] t_alarm;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // cooldown: time may not run backwards and the full gap must have passed
  function automatic logic gap_elapsed(logic [62:0] now, logic [62:0] last,
                                       logic [31:0] gap);
    return (now >= last) && ((now - last) >= {31'd0, gap});
  endfunction

  // update tracking for one frame and work out its action and presence pulse
  function automatic verdict_t qualify_frame(gaq_pkg::in_item_t f);
    verdict_t v;
    v.act = gaq_pkg::ACT_NONE;
    v.appeared = 1'b0;
    if (f.link_busy) begin
      trk_valid = 1'b0;
      trk_count = '0;
      trk_hand = 1'b0;
    end else if (!f.hand_detected) begin
      trk_hand = 1'b0;
    end else begin
      if (!trk_hand) begin
        v.appeared = 1'b1;
        trk_hand = 1'b1;
      end
      if (!f.best_valid || f.best_score < thr || f.best_class == gaq_pkg::CLS_NONE) begin
        trk_valid = 1'b0;
        trk_count = '0;
      end else begin
        if (trk_valid && trk_class == f.best_class) begin
          if (trk_count != gaq_pkg::COUNT_MAX) trk_count = trk_count + 8'd1;
        end else begin
          trk_valid = 1'b1;
          trk_class = f.best_class;
          trk_count = 8'd1;
        end
        if (trk_count >= need_frames) begin
          if (f.best_class == gaq_pkg::CLS_FIVE && f.palm_votes >= min_hands) begin
            if (gap_elapsed(f.now_time, t_alarm, cd_alarm)) begin
              t_alarm = f.now_time;
              v.act = gaq_pkg::ACT_EMERGENCY;
            end
          end else if (f.best_class == gaq_pkg::CLS_OK) begin
            if (gap_elapsed(f.now_time, t_photo, cd_photo)) begin
              t_photo = f.now_time;
              v.act = gaq_pkg::ACT_PHOTO;
            end
          end else if (f.best_class == gaq_pkg::CLS_ONE) begin
            if (gap_elapsed(f.now_time, t_video, cd_video)) begin
              t_video = f.now_time;
              v.act = gaq_pkg::ACT_VIDEO;
            end
          end else if (gap_elapsed(f.now_time, t_key, cd_key)) begin
            case (f.best_class)
              gaq_pkg::CLS_TWO:     v.act = gaq_pkg::ACT_PLAY_PAUSE;
              gaq_pkg::CLS_THREE:   v.act = gaq_pkg::ACT_NEXT;
              gaq_pkg::CLS_FOUR:    v.act = gaq_pkg::ACT_PREV;
              gaq_pkg::CLS_LIKE:    v.act = gaq_pkg::ACT_VOL_UP;
              gaq_pkg::CLS_DISLIKE: v.act = gaq_pkg::ACT_VOL_DOWN;
              default:              v.act = gaq_pkg::ACT_NONE;
            endcase
            if (v.act != gaq_pkg::ACT_NONE) t_key = f.now_time;
          end
          if (v.act != gaq_pkg::ACT_NONE) trk_count = '0;
        end
      end
    end
    return v;
  endfunction

  function automatic logic [95:0] pack_frame(gaq_pkg::in_item_t f);
    return {6'd0, f.now_time, f.palm_votes, f.best_score, f.best_class,
            f.best_valid, f.hand_detected, f.link_busy};
  endfunction

  // time base for random frames: mostly forward, sometimes still, backwards or far off
  function automatic logic [62:0] advance_clock();
    int unsigned pick;
    logic [62:0] back;
    pick = $urandom_range(99);
    if (pick >= 8) begin
      if (pick < 45) begin
        clock_us = clock_us + 63'($urandom_range(600000));
      end else if (pick < 85) begin
        clock_us = clock_us + 63'($urandom_range(13000000));
      end else if (pick < 92) begin
        back = 63'($urandom_range(1, 2000000));
        clock_us = (clock_us > back) ? clock_us - back : '0;
      end else if (pick < 98) begin
        clock_us = 63'({$urandom, $urandom});
      end else begin
        clock_us = '1;
      end
    end
    return clock_us;
  endfunction

  task automatic push_frame(logic busy, logic hand, logic bvalid, logic [3:0] cls,
                            logic [15:0] score, logic [3:0] votes, logic [62:0] now);
    gaq_pkg::in_item_t f;
    f.link_busy = busy;
    f.hand_detected = hand;
    f.best_valid = bvalid;
    f.best_class = cls;
    f.best_score = score;
    f.palm_votes = votes;
    f.now_time = now;
    frame_q = {frame_q, f};
  endtask

  // register write at a clock edge, mirrored into the predictor
  task automatic set_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      gaq_pkg::CFG_SCORE_THRESHOLD: thr = value[15:0];
      gaq_pkg::CFG_STABLE_FRAMES:   need_frames = value[7:0];
      gaq_pkg::CFG_PHOTO_COOLDOWN:  cd_photo = value;
      gaq_pkg::CFG_VIDEO_COOLDOWN:  cd_video = value;
      gaq_pkg::CFG_KEY_COOLDOWN:    cd_key = value;
      gaq_pkg::CFG_ALARM_COOLDOWN:  cd_alarm = value;
      gaq_pkg::CFG_ALARM_MIN_HANDS: min_hands = value[3:0];
      default: ;
    endcase
  endtask

  task automatic set_idle(int unsigned send_pct, int unsigned recv_pct);
    @(negedge clk_i);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // wait until every frame went in and every verdict came out
  task automatic drain();
    while (frame_q.size() != 0 || verdict_q.size() != 0 || s_tvalid_i)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // hand-built frames under the reset configuration
  task automatic run_directed();
    logic [3:0] keys[5];
    logic [62:0] t;
    keys = '{gaq_pkg::CLS_TWO, gaq_pkg::CLS_THREE, gaq_pkg::CLS_FOUR,
             gaq_pkg::CLS_LIKE, gaq_pkg::CLS_DISLIKE};
    t = 63'd20000000;
    // busy link, missing hand, hand appearing without a best result
    push_frame(1'b1, 1'b1, 1'b1, gaq_pkg::CLS_OK, 16'hFFFF, 4'd2, t);
    push_frame(1'b0, 1'b0, 1'b1, gaq_pkg::CLS_OK, 16'hFFFF, 4'd2, t + 63'd10);
    push_frame(1'b0, 1'b1, 1'b0, gaq_pkg::CLS_OK, 16'hFFFF, 4'd2, t + 63'd20);
    // class none and a score just under the threshold clear the label
    push_frame(1'b0, 1'b1, 1'b1, gaq_pkg::CLS_NONE, 16'hFFFF, 4'd2, t + 63'd30);
    push_frame(1'b0, 1'b1, 1'b1, gaq_pkg::CLS_OK, gaq_pkg::RST_SCORE_THRESHOLD - 16'd1,
               4'd0, t + 63'd40);
    // score right at the threshold counts, second frame takes a photo
    push_frame(1'b0, 1'b1, 1'b1, gaq_pkg::CLS_OK, gaq_pkg::RST_SCORE_THRESHOLD,
               4'd0, t + 63'd50);
    push_frame(1'b0, 1'b1, 1'b1, gaq_pkg::CLS_OK, 16'hFFFF, 4'hF, t + 63'd60);
    // time running backwards never passes the cooldown
    push_frame(1'b0, 1'b1, 1'b1, gaq_pkg::CLS_OK, 16'hFFFF, 4'd0, 63'd1000);
    push_frame(1'b0, 1'b1, 1'b1, gaq_pkg::CLS_OK, 16'hFFFF, 4'd0, 63'd1000);
    push_frame(1'b0, 1'b1, 1'b1, gaq_pkg::CLS_ONE, 16'hFFFF, 4'd0, t + 63'd70);
    push_frame(1'b0, 1'b1, 1'b1, gaq_pkg::CLS_ONE, 16'hFFFF, 4'd0, t + 63'd80);
    // every media key, spaced past the shared cooldown
    foreach (keys[k]) begin
      t = t + 63'd600000;
      push_frame(1'b0, 1'b1, 1'b1, keys[k], 16'hFFFF, 4'd0, t);
      t = t + 63'd600000;
      push_frame(1'b0, 1'b1, 1'b1, keys[k], 16'hFFFF, 4'd0, t);
    end
    // open palm with full votes raises the alarm
    push_frame(1'b0, 1'b1, 1'b1, gaq_pkg::CLS_FIVE, 16'hFFFF, 4'd8, t + 63'd100);
    push_frame(1'b0, 1'b1, 1'b1, gaq_pkg::CLS_FIVE, 16'hFFFF, 4'd8, t + 63'd200);
    // unknown class at the end of time: tracked, never acted on
    push_frame(1'b0, 1'b1, 1'b1, CLS_OTHER_MAX, 16'hFFFF, 4'd0, '1);
    push_frame(1'b0, 1'b1, 1'b1, CLS_OTHER_MAX, 16'hFFFF, 4'd0, '1);
    clock_us = t;
  endtask

  // mostly runs of one usable class, the rest noise frames
  task automatic gen_random(int unsigned n);
    int unsigned made;
    int unsigned run_len;
    logic [3:0] cls;
    gaq_pkg::in_item_t f;
    made = 0;
    while (made < n) begin
      if ($urandom_range(99) < 70) begin
        cls = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
        run_len = $urandom_range(1, int'(need_frames) + 3);
        for (int unsigned i = 0; i < run_len && made < n; i++) begin
          f.link_busy = ($urandom_range(49) == 0);
          f.hand_detected = ($urandom_range(29) != 0);
          f.best_valid = ($urandom_range(29) != 0);
          f.best_class = cls;
          f.best_score = 16'($urandom_range(65535, int'(thr)));
          f.palm_votes = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                                  : 4'($urandom_range(8));
          f.now_time = advance_clock();
          frame_q = {frame_q, f};
          made++;
        end
      end else begin
        f.link_busy = 1'($urandom_range(1));
        f.hand_detected = 1'($urandom_range(1));
        f.best_valid = 1'($urandom_range(1));
        f.best_class = 4'($urandom_range(15));
        f.best_score = 16'($urandom_range(65535));
        f.palm_votes = 4'($urandom_range(15));
        f.now_time = advance_clock();
        frame_q = {frame_q, f};
        made++;
      end
    end
  endtask

  task automatic cfg_random();
    set_reg(gaq_pkg::CFG_SCORE_THRESHOLD, {16'($urandom), 16'($urandom_range(40000))});
    set_reg(gaq_pkg::CFG_STABLE_FRAMES, {24'($urandom), 8'($urandom_range(1, 6))});
    set_reg(gaq_pkg::CFG_PHOTO_COOLDOWN, $urandom_range(3000000));
    set_reg(gaq_pkg::CFG_VIDEO_COOLDOWN, $urandom_range(3000000));
    set_reg(gaq_pkg::CFG_KEY_COOLDOWN, $urandom_range(3000000));
    set_reg(gaq_pkg::CFG_ALARM_COOLDOWN, $urandom_range(3000000));
    set_reg(gaq_pkg::CFG_ALARM_MIN_HANDS, {28'($urandom), 4'($urandom_range(8))});
  endtask

  // input side: present queued frames, predict each one on its transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
      s_tdata_i <= '0;
    end else begin
      if (s_tvalid_i && s_tready_o) begin
        verdict_q = {verdict_q, qualify_frame(frame_q.pop_front())};
      end
      if (!s_tvalid_i || s_tready_o) begin
        if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid_i <= 1'b1;
          s_tdata_i <= pack_frame(frame_q[0]);
        end else begin
          s_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // output side backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each output transfer with the oldest verdict
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (verdict_q.size() == 0) begin
        $error("output transfer with no frame outstanding: data %h", m_tdata_o);
        error_count++;
      end else begin
        due_verdict = verdict_q.pop_front();
        if (m_tdata_o[3:0] !== due_verdict.act) begin
          $error("action: expected %0d, got %0d", due_verdict.act, m_tdata_o[3:0]);
          error_count++;
        end
        if (m_tdata_o[4] !== due_verdict.appeared) begin
          $error("hand_appeared: expected %0d, got %0d", due_verdict.appeared, m_tdata_o[4]);
          error_count++;
        end
      end
    end
  end

  // phases: reset config with directed frames, both extremes, then random settings
  initial begin
    thr = gaq_pkg::RST_SCORE_THRESHOLD;
    need_frames = gaq_pkg::RST_STABLE_FRAMES;
    cd_photo = gaq_pkg::RST_PHOTO_COOLDOWN;
    cd_video = gaq_pkg::RST_VIDEO_COOLDOWN;
    cd_key = gaq_pkg::RST_KEY_COOLDOWN;
    cd_alarm = gaq_pkg::RST_ALARM_COOLDOWN;
    min_hands = gaq_pkg::RST_ALARM_MIN_HANDS;
    trk_valid = 1'b0;
    trk_class = '0;
    trk_count = '0;
    trk_hand = 1'b0;
    t_photo = '0;
    t_video = '0;
    t_key = '0;
    t_alarm = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_idle(0, 0);
    run_directed();
    gen_random(100);
    drain();

    // low extremes, junk in the unused write bits
    set_reg(gaq_pkg::CFG_SCORE_THRESHOLD, 32'hFFFF_0000);
    set_reg(gaq_pkg::CFG_STABLE_FRAMES, 32'hFFFF_FF00);
    set_reg(gaq_pkg::CFG_PHOTO_COOLDOWN, 32'h0000_0000);
    set_reg(gaq_pkg::CFG_VIDEO_COOLDOWN, 32'h0000_0000);
    set_reg(gaq_pkg::CFG_KEY_COOLDOWN, 32'h0000_0000);
    set_reg(gaq_pkg::CFG_ALARM_COOLDOWN, 32'h0000_0000);
    set_reg(gaq_pkg::CFG_ALARM_MIN_HANDS, 32'hFFFF_FFF0);
    set_idle(47, 0);
    gen_random(200);
    drain();

    // high extremes, plus a write to the unused index
    set_reg(gaq_pkg::CFG_SCORE_THRESHOLD, 32'h0000_FFFF);
    set_reg(gaq_pkg::CFG_STABLE_FRAMES, 32'h0000_00FF);
    set_reg(gaq_pkg::CFG_PHOTO_COOLDOWN, 32'hFFFF_FFFF);
    set_reg(gaq_pkg::CFG_VIDEO_COOLDOWN, 32'hFFFF_FFFF);
    set_reg(gaq_pkg::CFG_KEY_COOLDOWN, 32'hFFFF_FFFF);
    set_reg(gaq_pkg::CFG_ALARM_COOLDOWN, 32'hFFFF_FFFF);
    set_reg(gaq_pkg::CFG_ALARM_MIN_HANDS, 32'h0000_000F);
    set_reg(CFG_IDX_SPARE, 32'h0000_0001);
    set_idle(0, 47);
    gen_random(350);
    drain();

    for (int p = 0; p < 4; p++) begin
      cfg_random();
      case (p)
        0: set_idle(23, 23);
        1: set_idle(0, 0);
        2: set_idle(47, 0);
        default: set_idle(0, 47);
      endcase
      gen_random(200);
      drain();
    end

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
